@@ sv/trimmed_sample_statistics_core_defines.svh @@
// assertion macros shared by the rtl files
`ifndef TRIMMED_SAMPLE_STATISTICS_CORE_DEFINES_SVH
`define TRIMMED_SAMPLE_STATISTICS_CORE_DEFINES_SVH

// property that holds every cycle out of reset
`define TSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked on the next cycle
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// types, constants and codes of the trimmed sample statistics core
// ----------------------------------------------------------------------------
`default_nettype none
package tss_pkg;

    localparam int STORE_DEPTH_DEF = 64;
    localparam int CFG_W = 7;
    localparam int CNT_W = 7;

    localparam logic [0:0] CFG_EXCL_SMALL = 1'b0;
    localparam logic [0:0] CFG_EXCL_LARGE = 1'b1;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_CLOSE = 1'b1;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_STATS = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic        action;
        logic [63:0] timestamp;
        logic signed [31:0] sample_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  sample_count;
        logic        min_valid;
        logic signed [31:0] min_value;
        logic [63:0] min_time;
        logic        max_valid;
        logic signed [31:0] max_value;
        logic [63:0] max_time;
        logic        mean_valid;
        logic signed [31:0] mean_value;
        logic [63:0] mean_time;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_WRITE,
        S_RD_MIN,
        S_RD_MAX,
        S_SUM,
        S_DIV,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take_in;     // latch input word
        logic srch_start;  // start position search
        logic shift_start; // start shifting above pos
        logic wr_new;      // write new entry
        logic rd_min;
        logic rd_max;
        logic sum_start;
        logic div_start;
        logic make_add;    // build add or drop result
        logic make_close;  // build close result, clear count
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_close;
        logic full;
        logic empty;
        logic srch_done;
        logic shift_done;
        logic sum_done;
        logic div_done;
        logic mean_ok;
    } t_sts;

endpackage
`default_nettype wire

@@ sv/tss_ctrl.sv @@
// ----------------------------------------------------------------------------
// tss_ctrl
// sequencer for add and close words
// ----------------------------------------------------------------------------
`default_nettype none
`include "trimmed_sample_statistics_core_defines.svh"
module tss_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic          i_out_busy,
    input  wire tss_pkg::t_sts i_sts,
    output tss_pkg::t_cmd      o_cmd
);
    tss_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_stall = 1'b1;
        case (r_state)
            tss_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state = tss_pkg::S_SEARCH;
                end
            end
            tss_pkg::S_SEARCH: begin
                if (i_sts.is_close) begin
                    if (i_sts.empty) begin
                        n_state = tss_pkg::S_OUT;
                    end else begin
                        o_cmd.rd_min = 1'b1;
                        n_state = tss_pkg::S_RD_MIN;
                    end
                end else if (i_sts.full) begin
                    n_state = tss_pkg::S_OUT;
                end else begin
                    o_cmd.srch_start = 1'b1;
                    n_state = tss_pkg::S_SHIFT;
                end
            end
            tss_pkg::S_SHIFT: begin
                if (i_sts.srch_done) begin
                    o_cmd.shift_start = 1'b1;
                    n_state = tss_pkg::S_WRITE;
                end
            end
            tss_pkg::S_WRITE: begin
                if (i_sts.shift_done) begin
                    o_cmd.wr_new = 1'b1;
                    n_state = tss_pkg::S_OUT;
                end
            end
            tss_pkg::S_RD_MIN: begin
                o_cmd.rd_max = 1'b1;
                n_state = tss_pkg::S_RD_MAX;
            end
            tss_pkg::S_RD_MAX: begin
                o_cmd.sum_start = 1'b1;
                n_state = tss_pkg::S_SUM;
            end
            tss_pkg::S_SUM: begin
                if (i_sts.sum_done) begin
                    o_cmd.div_start = i_sts.mean_ok;
                    n_state = tss_pkg::S_DIV;
                end
            end
            tss_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = tss_pkg::S_OUT;
                end
            end
            tss_pkg::S_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.make_add = !i_sts.is_close;
                    o_cmd.make_close = i_sts.is_close;
                    n_state = tss_pkg::S_IDLE;
                end
            end
            default: n_state = tss_pkg::S_IDLE;
        endcase
    end

    `TSS_ASSERT(a_one_result, !(o_cmd.make_add && o_cmd.make_close), "add and close together")
    `TSS_ASSERT_NEXT(a_take_leaves_idle, o_cmd.take_in, r_state == tss_pkg::S_SEARCH,
        "accepted word did not start")
    `TSS_ASSERT(a_stall_idle, o_in_stall || r_state == tss_pkg::S_IDLE, "accept while busy")
endmodule
`default_nettype wire

@@ sv/tss_dpath.sv @@
// ----------------------------------------------------------------------------
// tss_dpath
// sorted store, search, shift, sum, divider and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "trimmed_sample_statistics_core_defines.svh"
module tss_dpath #(
    parameter int STORE_DEPTH = tss_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire tss_pkg::t_in_word       i_in_word,
    input  wire logic                    i_cfg_we,
    input  wire logic [0:0]              i_cfg_idx,
    input  wire logic [tss_pkg::CFG_W-1:0] i_cfg_data,
    input  wire tss_pkg::t_cmd           i_cmd,
    output tss_pkg::t_sts                o_sts,
    input  wire logic                    i_out_stall,
    output logic                         o_out_valid,
    output tss_pkg::t_out_word           o_out_word
);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int NW = $clog2(STORE_DEPTH + 1);
    localparam int XW = (NW > tss_pkg::CFG_W ? NW : tss_pkg::CFG_W) + 1;
    localparam int SW = 32 + NW;

    logic signed [31:0] r_vals [STORE_DEPTH];
    logic [63:0]        r_tims [STORE_DEPTH];

    logic [NW-1:0] r_cnt;
    logic [tss_pkg::CFG_W-1:0] r_xs, r_xl;
    tss_pkg::t_in_word r_in;
    logic r_was_full;  // store was full when the word was taken

    // one read port and one write port per cycle
    logic [AW-1:0] rd_addr;
    logic signed [31:0] r_rd_val;
    logic [63:0]        r_rd_tim;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic signed [31:0] wr_val;
    logic [63:0] wr_tim;

    typedef enum logic [2:0] {P_NONE, P_SRCH, P_SHIFT, P_SUM, P_DIV} t_phase;
    t_phase r_ph;
    logic [NW-1:0] r_ptr;     // walking index
    logic          r_rd_ok;   // read data registered this cycle is useful
    logic [NW-1:0] r_rd_idx;  // index of registered read data
    logic [NW-1:0] r_pos;
    logic          r_srch_done, r_shift_done, r_sum_done, r_div_done;

    // trimming arithmetic
    logic [XW-1:0] xs_w, xl_w, cnt_w, tr_w;
    logic min_ok, max_ok, mean_ok;
    logic [NW-1:0] max_idx, m_cnt, end_idx;
    assign xs_w = XW'(r_xs);
    assign xl_w = XW'(r_xl);
    assign cnt_w = XW'(r_cnt);
    assign tr_w = xs_w + xl_w;
    assign min_ok = xs_w < cnt_w;
    assign max_ok = xl_w < cnt_w;
    assign mean_ok = tr_w < cnt_w;
    assign max_idx = NW'(cnt_w - xl_w - XW'(1));
    assign m_cnt = NW'(cnt_w - tr_w);
    assign end_idx = NW'(cnt_w - xl_w);

    logic signed [SW-1:0] r_sum;
    // divider state
    logic [SW-1:0] r_rem, r_quo;
    logic [5:0]    r_bit;
    logic          r_neg;
    logic [SW:0]   trial;

    tss_pkg::t_out_word r_res;
    logic r_min_v, r_max_v;
    logic signed [31:0] r_min_val, r_max_val;
    logic [63:0] r_min_tim, r_max_tim, r_mean_tim;
    logic r_grab_min, r_grab_max;

    always_comb begin
        rd_addr = AW'(r_ptr);
        // shift reads the entry below the walking index
        if (r_ph == P_SHIFT) rd_addr = AW'(r_ptr - NW'(1));
        if (i_cmd.rd_min) rd_addr = AW'(r_xs);
        if (i_cmd.rd_max) rd_addr = AW'(max_idx);
    end

    always_ff @(posedge i_clk) begin
        r_rd_val <= r_vals[rd_addr];
        r_rd_tim <= r_tims[rd_addr];
        if (wr_en) begin
            r_vals[wr_addr] <= wr_val;
            r_tims[wr_addr] <= wr_tim;
        end
    end

    always_comb begin
        wr_en = 1'b0;
        wr_addr = AW'(r_rd_idx + NW'(1));
        wr_val = r_rd_val;
        wr_tim = r_rd_tim;
        if (r_ph == P_SHIFT && r_rd_ok) wr_en = 1'b1;
        if (i_cmd.wr_new) begin
            wr_en = 1'b1;
            wr_addr = AW'(r_pos);
            wr_val = r_in.sample_value;
            wr_tim = r_in.timestamp;
        end
    end

    assign trial = {r_rem[SW-1:0], r_quo[SW-1]} - {1'b0, SW'(m_cnt)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_xs <= '0;
            r_xl <= '0;
            r_ph <= P_NONE;
            r_rd_ok <= 1'b0;
            r_srch_done <= 1'b0;
            r_shift_done <= 1'b0;
            r_sum_done <= 1'b0;
            r_div_done <= 1'b0;
            o_out_valid <= 1'b0;
            r_grab_min <= 1'b0;
            r_grab_max <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == tss_pkg::CFG_EXCL_SMALL) r_xs <= i_cfg_data;
                else r_xl <= i_cfg_data;
            end
            if (o_out_valid && !i_out_stall) o_out_valid <= 1'b0;
            r_grab_min <= i_cmd.rd_min;
            r_grab_max <= i_cmd.rd_max;
            if (i_cmd.take_in) begin
                r_srch_done <= 1'b0;
                r_shift_done <= 1'b0;
                r_sum_done <= 1'b0;
                r_div_done <= 1'b0;
            end
            r_rd_ok <= 1'b0;
            case (r_ph)
                P_SRCH: begin
                    // registered read of entry r_rd_idx
                    if (r_rd_ok && r_rd_val >= r_in.sample_value) begin
                        r_pos <= r_rd_idx;
                        r_srch_done <= 1'b1;
                        r_ph <= P_NONE;
                    end else if (r_ptr >= r_cnt && !r_rd_ok) begin
                        r_pos <= r_cnt;
                        r_srch_done <= 1'b1;
                        r_ph <= P_NONE;
                    end else if (r_ptr < r_cnt) begin
                        r_rd_ok <= 1'b1;
                        r_rd_idx <= r_ptr;
                        r_ptr <= r_ptr + NW'(1);
                    end
                end
                P_SHIFT: begin
                    // walk down from top, copying entry k to k+1
                    if (r_ptr > r_pos) begin
                        r_rd_ok <= 1'b1;
                        r_rd_idx <= r_ptr - NW'(1);
                        r_ptr <= r_ptr - NW'(1);
                    end else begin
                        r_shift_done <= 1'b1;
                        r_ph <= P_NONE;
                    end
                end
                P_SUM: begin
                    if (r_rd_ok) r_sum <= r_sum + SW'(r_rd_val);
                    if (r_ptr < end_idx) begin
                        r_rd_ok <= 1'b1;
                        r_ptr <= r_ptr + NW'(1);
                    end else if (!r_rd_ok) begin
                        r_sum_done <= 1'b1;
                        r_ph <= P_NONE;
                    end
                end
                P_DIV: begin
                    if (!trial[SW]) r_rem <= trial[SW-1:0];
                    else r_rem <= {r_rem[SW-2:0], r_quo[SW-1]};
                    r_quo <= {r_quo[SW-2:0], !trial[SW]};
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd0) begin
                        r_div_done <= 1'b1;
                        r_ph <= P_NONE;
                    end
                end
                default: ;
            endcase
            if (i_cmd.srch_start) begin
                r_ph <= P_SRCH;
                r_ptr <= '0;
            end
            if (i_cmd.shift_start) begin
                r_ph <= P_SHIFT;
                r_ptr <= r_cnt;
            end
            if (i_cmd.sum_start) begin
                r_ph <= P_SUM;
                r_ptr <= NW'(xs_w);
                r_sum <= '0;
                if (!mean_ok) r_ph <= P_NONE;
                if (!mean_ok) r_sum_done <= 1'b1;
            end
            if (i_cmd.div_start) begin
                r_ph <= P_DIV;
                r_neg <= r_sum[SW-1];
                r_quo <= r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
                r_rem <= '0;
                r_bit <= 6'(SW - 1);
            end else if (i_cmd.sum_start == 1'b0 && r_sum_done && !mean_ok) begin
                r_div_done <= 1'b1;
            end
            if (i_cmd.wr_new) r_cnt <= r_cnt + NW'(1);
            if (i_cmd.make_add || i_cmd.make_close) o_out_valid <= 1'b1;
            if (i_cmd.make_close) r_cnt <= '0;
        end
    end

    // payload capture, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_in <= i_in_word;
            r_was_full <= o_sts.full;
        end
        if (r_grab_min) begin
            r_min_val <= r_rd_val;
            r_min_tim <= r_rd_tim;
            r_mean_tim <= r_rd_tim;
        end
        if (r_grab_max) begin
            r_max_val <= r_rd_val;
            r_max_tim <= r_rd_tim;
        end
        if (i_cmd.make_add) begin
            r_res <= '0;
            r_res.status <= r_was_full ? tss_pkg::ST_DROPPED : tss_pkg::ST_ADDED;
            r_res.sample_count <= 7'(r_cnt);
        end
        if (i_cmd.make_close) begin
            r_res <= '0;
            r_res.sample_count <= 7'(r_cnt);
            if (r_cnt == '0) begin
                r_res.status <= tss_pkg::ST_EMPTY;
            end else begin
                r_res.status <= tss_pkg::ST_STATS;
                r_res.min_valid <= min_ok;
                r_res.min_value <= min_ok ? r_min_val : '0;
                r_res.min_time <= min_ok ? r_min_tim : '0;
                r_res.max_valid <= max_ok;
                r_res.max_value <= max_ok ? r_max_val : '0;
                r_res.max_time <= max_ok ? r_max_tim : '0;
                r_res.mean_valid <= mean_ok;
                r_res.mean_value <= mean_ok ?
                    (r_neg ? 32'(-r_quo) : 32'(r_quo)) : '0;
                r_res.mean_time <= mean_ok ? r_mean_tim : '0;
            end
        end
    end

    assign o_out_word = r_res;
    assign o_sts.is_close = r_in.action == tss_pkg::ACT_CLOSE;
    assign o_sts.full = r_cnt >= NW'(STORE_DEPTH);
    assign o_sts.empty = r_cnt == '0;
    assign o_sts.srch_done = r_srch_done;
    assign o_sts.shift_done = r_shift_done;
    assign o_sts.sum_done = r_sum_done;
    assign o_sts.div_done = r_div_done;
    assign o_sts.mean_ok = mean_ok;

    `TSS_ASSERT(a_cnt_bound, r_cnt <= NW'(STORE_DEPTH), "count above depth")
    `TSS_ASSERT_NEXT(a_close_clears, i_cmd.make_close, r_cnt == '0, "close left entries")
    `TSS_ASSERT(a_no_write_full, !(i_cmd.wr_new && o_sts.full), "write into full store")
endmodule
`default_nettype wire

@@ sv/trimmed_sample_statistics_core.sv @@
// add: search finds the entry position, shift moves the entries above it up, then the new entry is written
// close: min, max, then m untrimmed entries summed and a 39-step divider, skipped with no mean
// empty close or dropped add: straight to the result; next word is taken the cycle after the result is made
// reset: count and trim registers clear to zero, store contents are left as is
// ----------------------------------------------------------------------------
// trimmed_sample_statistics_core
// value-sorted sample store with trimmed min, max and mean report on close
// ----------------------------------------------------------------------------
`default_nettype none
module trimmed_sample_statistics_core #(
    parameter int STORE_DEPTH = tss_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [0:0]                i_cfg_idx,
    input  wire logic [tss_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire tss_pkg::t_in_word         i_in_word,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output tss_pkg::t_out_word             o_out_word
);
    tss_pkg::t_cmd cmd;
    tss_pkg::t_sts sts;

    tss_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .i_out_busy(o_out_valid && i_out_stall),
        .i_sts(sts), .o_cmd(cmd)
    );

    tss_dpath #(.STORE_DEPTH(STORE_DEPTH)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_word(i_in_word),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_cmd(cmd), .o_sts(sts), .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid), .o_out_word(o_out_word)
    );
endmodule
`default_nettype wire

@@ tb/sv/trimmed_sample_statistics_core_test.sv @@
// ----------------------------------------------------------------------------
// trimmed_sample_statistics_core_test
// drives add and close words into the sorted sample store under varied trim
// settings and idling, predicts every result word and checks it field by field
// ----------------------------------------------------------------------------
`default_nettype none

class sample_stats_scoreboard;
    logic signed [31:0] store_val[64];
    logic [63:0]        store_time[64];
    int                 held;
    int                 trim_low;
    int                 trim_high;
    tss_pkg::t_out_word pending[$];
    int                 errors;
    int                 checked;
    int                 closes;

    function new();
        held = 0;
        trim_low = 0;
        trim_high = 0;
        errors = 0;
        checked = 0;
        closes = 0;
    endfunction

    function void report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch on %s: got %h, expected %h", what, got, want);
    endfunction

    function void set_trim(logic idx, int value);
        if (idx == tss_pkg::CFG_EXCL_SMALL) trim_low = value;
        else trim_high = value;
    endfunction

    // predict the result for an accepted input word
    function void note_input(tss_pkg::t_in_word w);
        tss_pkg::t_out_word r;
        int pos;
        int top;
        int m;
        longint sum;
        r = '0;
        if (w.action == tss_pkg::ACT_ADD) begin
            if (held >= 64) begin
                r.status = tss_pkg::ST_DROPPED;
            end else begin
                pos = 0;
                while (pos < held && store_val[pos] < w.sample_value) pos++;
                for (int i = held; i > pos; i--) begin
                    store_val[i] = store_val[i-1];
                    store_time[i] = store_time[i-1];
                end
                store_val[pos] = w.sample_value;
                store_time[pos] = w.timestamp;
                held++;
                r.status = tss_pkg::ST_ADDED;
            end
            r.sample_count = held[6:0];
        end else if (held == 0) begin
            r.status = tss_pkg::ST_EMPTY;
        end else begin
            closes++;
            r.status = tss_pkg::ST_STATS;
            r.sample_count = held[6:0];
            if (trim_low < held) begin
                r.min_valid = 1'b1;
                r.min_value = store_val[trim_low];
                r.min_time = store_time[trim_low];
            end
            if (trim_high < held) begin
                top = held - trim_high - 1;
                r.max_valid = 1'b1;
                r.max_value = store_val[top];
                r.max_time = store_time[top];
            end
            if (trim_low + trim_high < held) begin
                m = held - trim_low - trim_high;
                sum = 0;
                for (int i = 0; i < m; i++) sum += longint'(store_val[trim_low + i]);
                r.mean_valid = 1'b1;
                r.mean_value = 32'(sum / longint'(m));
                r.mean_time = store_time[trim_low];
            end
            held = 0;
        end
        pending.push_back(r);
    endfunction

    function void check_result(tss_pkg::t_out_word got);
        tss_pkg::t_out_word e;
        if (pending.size() == 0) begin
            errors++;
            $display("result word with nothing expected: %h", got);
            return;
        end
        e = pending.pop_front();
        checked++;
        if (got.status !== e.status) report_mismatch("status", got.status, e.status);
        if (got.sample_count !== e.sample_count)
            report_mismatch("sample_count", got.sample_count, e.sample_count);
        if (got.min_valid !== e.min_valid) report_mismatch("min_valid", got.min_valid, e.min_valid);
        if (got.min_value !== e.min_value)
            report_mismatch("min_value", 32'(got.min_value), 32'(e.min_value));
        if (got.min_time !== e.min_time) report_mismatch("min_time", got.min_time, e.min_time);
        if (got.max_valid !== e.max_valid) report_mismatch("max_valid", got.max_valid, e.max_valid);
        if (got.max_value !== e.max_value)
            report_mismatch("max_value", 32'(got.max_value), 32'(e.max_value));
        if (got.max_time !== e.max_time) report_mismatch("max_time", got.max_time, e.max_time);
        if (got.mean_valid !== e.mean_valid)
            report_mismatch("mean_valid", got.mean_valid, e.mean_valid);
        if (got.mean_value !== e.mean_value)
            report_mismatch("mean_value", 32'(got.mean_value), 32'(e.mean_value));
        if (got.mean_time !== e.mean_time) report_mismatch("mean_time", got.mean_time, e.mean_time);
    endfunction
endclass

module trimmed_sample_statistics_core_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [tss_pkg::CFG_W-1:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    tss_pkg::t_in_word  i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    tss_pkg::t_out_word o_out_word;

    sample_stats_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_request;
    int  sent_words;

    trimmed_sample_statistics_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("trimmed_sample_statistics_core test failed");
        $finish;
    end

    // receiver: random stall plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0) hold_left--;
            i_out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_word);
    end

    task automatic write_trim(logic [0:0] idx, int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[tss_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_trim(idx, value);
    endtask

    // stop offering words and wait for every expected result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_trims(int low, int high);
        wait_drained();
        write_trim(tss_pkg::CFG_EXCL_SMALL, low);
        write_trim(tss_pkg::CFG_EXCL_LARGE, high);
    endtask

    task automatic send_word(logic act, logic [63:0] ts, logic signed [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= '{action: act, timestamp: ts, sample_value: v};
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(i_in_word);
        sent_words++;
    endtask

    function automatic logic signed [31:0] pick_value(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(6)) - 3);
            2: return $urandom_range(1) ? 32'sh7fff_ffff - $urandom_range(3)
                                         : 32'sh8000_0000 + $urandom_range(3);
            default: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
        endcase
    endfunction

    // one interval: a burst of adds then a close
    task automatic send_interval();
        int len;
        int mode;
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) len = $urandom_range(20);
        else if (roll < 95) len = $urandom_range(64, 40);
        else len = $urandom_range(70, 64);
        mode = $urandom_range(3);
        for (int i = 0; i < len; i++)
            send_word(tss_pkg::ACT_ADD, {$urandom, $urandom}, pick_value(mode));
        if ($urandom_range(19) == 0)
            send_word(tss_pkg::ACT_ADD, {$urandom, $urandom}, pick_value(0));
        send_word(tss_pkg::ACT_CLOSE, {$urandom, $urandom}, $urandom);
        if ($urandom_range(9) == 0)
            send_word(tss_pkg::ACT_CLOSE, {$urandom, $urandom}, $urandom);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int words);
        int stop_at;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = sent_words + words;
        while (sent_words < stop_at) send_interval();
    endtask

    initial begin
        sb = new();
        hold_request = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent_words = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty close, extremes, equal values, full store
        send_word(tss_pkg::ACT_CLOSE, '0, '0);
        send_word(tss_pkg::ACT_ADD, 64'hffff_ffff_ffff_ffff, 32'sh7fff_ffff);
        send_word(tss_pkg::ACT_ADD, 64'h0, 32'sh8000_0000);
        send_word(tss_pkg::ACT_ADD, 64'h1, 32'sh0000_0000);
        send_word(tss_pkg::ACT_ADD, 64'h2, 32'sh0000_0000);
        send_word(tss_pkg::ACT_ADD, 64'h3, 32'shffff_ffff);
        send_word(tss_pkg::ACT_CLOSE, '1, '1);
        set_trims(1, 2);
        for (int i = 0; i < 5; i++) send_word(tss_pkg::ACT_ADD, 64'(i), 32'sh8000_0000);
        send_word(tss_pkg::ACT_CLOSE, '0, '0);
        set_trims(2, 2);
        send_word(tss_pkg::ACT_ADD, 64'h10, 32'sh1_0000);
        send_word(tss_pkg::ACT_ADD, 64'h11, -32'sh3_0000);
        send_word(tss_pkg::ACT_CLOSE, '0, '0);
        set_trims(64, 64);
        for (int i = 0; i < 64; i++)
            send_word(tss_pkg::ACT_ADD, {$urandom, $urandom}, $urandom);
        send_word(tss_pkg::ACT_ADD, '1, 32'sh7fff_ffff);
        send_word(tss_pkg::ACT_CLOSE, '0, '0);
        set_trims(127, 127);
        send_word(tss_pkg::ACT_ADD, '0, '0);
        send_word(tss_pkg::ACT_CLOSE, '0, '0);

        set_trims(0, 0);
        run_phase(0, 0, 380);
        set_trims($urandom_range(5), $urandom_range(5));
        run_phase(60, 0, 380);
        // long receiver hold-off while the sender keeps offering words
        set_trims(63, 0);
        hold_request = 1'b1;
        run_phase(0, 0, 40);
        wait_drained();
        set_trims(0, 127);
        run_phase(0, 60, 380);
        set_trims($urandom_range(8), $urandom_range(8));
        run_phase(28, 28, 380);

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("sent %0d words, checked %0d results, %0d reports with statistics",
                 sent_words, sb.checked, sb.closes);
        $display("covered trim settings from 0 to 127 under four idling mixes");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("trimmed_sample_statistics_core test passed");
        end else begin
            $display("trimmed_sample_statistics_core test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
